[hdl/ansplit_pkg.sv]
// Shared types and constants of the Annex B NAL unit splitter.
// Used by the front, queue, back and top-level modules; no dependencies.
package ansplit_pkg;

  localparam int unsigned LineDepth     = 4;  // held bytes in the delay line
  localparam int unsigned WinDepth      = 5;  // held bytes plus the new one
  localparam int unsigned QueueDepthDef = 4;  // work entries between front and back

  localparam logic [7:0] ZeroByte = 8'h00;
  localparam logic [7:0] OneByte  = 8'h01;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       first_of_unit;
    logic       last_of_unit;
    logic       long_start_code;
  } out_beat_t;

  // One accepted input item turned into up to WinDepth output beats.
  typedef struct packed {
    logic [WinDepth-1:0]            emit;
    out_beat_t [WinDepth-1:0]       beat;
  } work_t;

endpackage

[hdl/ansplit_front.sv]
// Front of the splitter: delay line, start code detection and beat planning.
// Depends on ansplit_pkg; feeds work entries into ansplit_queue.
module ansplit_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  ansplit_pkg::in_beat_t in_beat_i,
  input  logic                  q_full_i,
  output logic                  in_stall_o,
  output logic                  push_o,
  output ansplit_pkg::work_t    work_o
);

  localparam int unsigned W = ansplit_pkg::WinDepth;
  localparam int unsigned L = ansplit_pkg::LineDepth;

  logic [L-1:0][7:0] pend_byte_q, pend_byte_d;
  logic [L-1:0]      pend_valid_q, pend_valid_d;
  logic [L-1:0]      pend_first_q, pend_first_d;
  logic              inside_q, inside_d;
  logic              long_q, long_d;

  logic [W-1:0][7:0] wb;
  logic [W-1:0]      wv;
  logic [W-1:0]      wf;
  logic [W-1:0]      cand;
  logic [W-1:0]      lng;
  logic [W-1:0]      last;
  logic              acc;
  logic              found;
  logic              short_sc;
  logic              inside_w;

  assign in_stall_o = q_full_i;
  assign acc        = in_valid_i && !q_full_i;

  always_comb begin
    wb = {in_beat_i.data_byte, pend_byte_q};
    wv = {1'b1, pend_valid_q};
    wf = {1'b0, pend_first_q};
    inside_w = inside_q;

    found = (in_beat_i.data_byte == ansplit_pkg::OneByte) &&
            wv[3] && (wb[3] == ansplit_pkg::ZeroByte) &&
            wv[2] && (wb[2] == ansplit_pkg::ZeroByte);
    short_sc = !(wv[1] && (wb[1] == ansplit_pkg::ZeroByte));

    if (found) begin
      // Drop bytes ahead of the first start code of each stream.
      if (!inside_q) begin
        wv[0] = 1'b0;
        if (short_sc) begin
          wv[1] = 1'b0;
        end
        inside_w = 1'b1;
      end
      if (short_sc) begin
        wf[2] = 1'b1;
      end else begin
        wf[1] = 1'b1;
      end
    end

    // A first byte is long when the byte two places later is a held zero.
    cand = '0;
    for (int i = 0; i < 3; i++) begin
      cand[i] = wv[i+2] && (wb[i+2] == ansplit_pkg::ZeroByte);
    end

    for (int i = 0; i < W; i++) begin
      if (i == 0) begin
        lng[i] = (wv[i] && wf[i]) ? cand[i] : long_q;
      end else begin
        lng[i] = (wv[i] && wf[i]) ? cand[i] : lng[i-1];
      end
    end

    for (int i = 0; i < W - 1; i++) begin
      last[i] = wv[i+1] && wf[i+1];
    end
    last[W-1] = 1'b1;

    for (int i = 0; i < W; i++) begin
      work_o.beat[i].out_byte        = wb[i];
      work_o.beat[i].first_of_unit   = wf[i];
      work_o.beat[i].last_of_unit    = last[i];
      work_o.beat[i].long_start_code = lng[i];
    end

    work_o.emit = '0;
    pend_byte_d  = wb[W-1:1];
    pend_valid_d = wv[W-1:1];
    pend_first_d = wf[W-1:1];
    inside_d     = inside_w;
    long_d       = long_q;

    if (in_beat_i.end_of_stream) begin
      // Flush every held unit byte and the new byte, then go back to the search state.
      if (inside_w) begin
        work_o.emit = wv;
      end
      pend_valid_d = '0;
      pend_first_d = '0;
      inside_d     = 1'b0;
      long_d       = 1'b0;
    end else begin
      work_o.emit[0] = inside_w && wv[0];
      if (inside_w && wv[0]) begin
        long_d = lng[0];
      end
    end
  end

  assign push_o = acc && (work_o.emit != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= '0;
      pend_first_q <= '0;
      inside_q     <= 1'b0;
      long_q       <= 1'b0;
    end else if (acc) begin
      pend_valid_q <= pend_valid_d;
      pend_first_q <= pend_first_d;
      inside_q     <= inside_d;
      long_q       <= long_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pend_byte_q <= pend_byte_d;
    end
  end

`ifndef SYNTHESIS
  a_eos_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_beat_i.end_of_stream |=> !inside_q && (pend_valid_q == '0))
    else $error("line not emptied after end of stream");

  a_single_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !in_beat_i.end_of_stream |-> (work_o.emit[W-1:1] == '0))
    else $error("more than one beat planned for a plain byte");
`endif

endmodule

[hdl/ansplit_queue.sv]
// Short register queue of work entries between front and back.
// Depends on ansplit_pkg for the entry type.
module ansplit_queue #(
  parameter int unsigned Depth = ansplit_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ansplit_pkg::work_t push_work_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               valid_o,
  output ansplit_pkg::work_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ansplit_pkg::work_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_work_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && !valid_o))
    else $error("queue overflow or underflow");
`endif

endmodule

[hdl/ansplit_back.sv]
// Back of the splitter: unpacks one work entry into output beats, lowest lane first.
// Depends on ansplit_pkg; pops entries from ansplit_queue.
module ansplit_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  ansplit_pkg::work_t     q_head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output ansplit_pkg::out_beat_t out_beat_o
);

  localparam int unsigned W = ansplit_pkg::WinDepth;

  ansplit_pkg::work_t cur_q;
  logic [W-1:0] mask_q, mask_d;
  logic [W-1:0] sel;
  logic [W-1:0] remaining;
  logic         fire;
  logic         load;

  assign sel       = mask_q & (~mask_q + 1'b1);
  assign remaining = mask_q & ~sel;

  assign out_valid_o = (mask_q != '0);
  assign fire        = out_valid_o && !out_stall_i;
  // Take the next entry when idle or when the final beat of this one leaves.
  assign load  = q_valid_i && (!out_valid_o || (fire && (remaining == '0)));
  assign pop_o = load;

  always_comb begin
    out_beat_o = '0;
    for (int i = 0; i < W; i++) begin
      if (sel[i]) begin
        out_beat_o = cur_q.beat[i];
      end
    end
    if (load) begin
      mask_d = q_head_i.emit;
    end else if (fire) begin
      mask_d = remaining;
    end else begin
      mask_d = mask_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_head_i;
    end
  end

`ifndef SYNTHESIS
  a_load_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (q_head_i.emit != '0))
    else $error("work entry without beats reached the back");
`endif

endmodule

[hdl/annexb_nal_unit_splitter_top.sv]
// Top level of the Annex B NAL unit splitter.
// Depends on ansplit_pkg, ansplit_front, ansplit_queue and ansplit_back.
//
//   channel | direction | handshake             | beat type
//   --------+-----------+-----------------------+------------------------
//   in      | input     | in_valid_i/in_stall_o | ansplit_pkg::in_beat_t
//   out     | output    | out_valid_o/out_stall_i | ansplit_pkg::out_beat_t
//
// Cycles: one input byte per clock unless the queue is full; a plain byte yields at
//   most one output beat, an end-of-stream byte up to five, sent one per clock unless stalled.
// The back stage loads the next queued entry in the cycle its last beat leaves,
//   so the output sustains one beat per clock while entries are queued and no stall.
// Reset: asynchronous, active low; clears the delay line valid bits, the unit
//   state, the queue pointers and the back stage lane mask.
// Stalls: in_stall_o rises only when the work queue is full; an out stall holds
//   the back stage while the front keeps filling the queue.
module annexb_nal_unit_splitter_top #(
  parameter int unsigned QueueDepth = ansplit_pkg::QueueDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  ansplit_pkg::in_beat_t  in_beat_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output ansplit_pkg::out_beat_t out_beat_o
);

  // Front to queue: planned beats of one accepted byte.
  logic               push;
  ansplit_pkg::work_t push_work;
  // Queue to back.
  logic               q_full;
  logic               q_valid;
  logic               pop;
  ansplit_pkg::work_t q_head;

  // Detect start codes and plan the beats of each accepted byte.
  ansplit_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_beat_i  (in_beat_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .work_o     (push_work)
  );

  // Decouple the byte-rate front from the stallable output.
  ansplit_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_work_i (push_work),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // Send the planned beats out in stream order.
  ansplit_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
